@@ rtl/core/spg_pkg.sv @@
`timescale 1ns / 1ps
package spg_pkg;

  localparam int unsigned TIMER_CLOCK_HZ = 1000000;
  localparam int unsigned PERIOD_MAX     = 65536;
  localparam int unsigned PERIOD_MIN     = 800;

  localparam int SPEED_W = 8;
  localparam int ANGLE_W = 14;
  localparam int MOVE_W  = 8;
  localparam int STEPS_W = 15;
  localparam int PER_W   = 17;
  localparam int CFG_DW  = 14;
  localparam int CFG_IW  = 2;

  // divider: dividend wide enough for the timer clock and for angle*100
  localparam int HZ_W   = $clog2(TIMER_CLOCK_HZ + 1);
  localparam int DIVD_W = (HZ_W > STEPS_W) ? HZ_W : STEPS_W;
  localparam int DVSR_W = 15;
  localparam int CNT_W  = $clog2(DIVD_W + 1);

  localparam int UPC_W = 4;

  localparam logic [CFG_IW-1:0] CFG_SPEED      = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_STEP_ANGLE = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_DIR        = 2'd2;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_MOVE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [MOVE_W-1:0]  angle_deg;
  } in_item_t;

  typedef struct packed {
    logic               step_level;
    logic               dir_level;
    logic               busy_res;
    logic [STEPS_W-1:0] steps_left;
    logic [PER_W-1:0]   period_ticks;
  } out_item_t;

  typedef enum logic [2:0] {
    UOP_NOP     = 3'd0,
    UOP_LD_FREQ = 3'd1,
    UOP_LD_PER  = 3'd2,
    UOP_LD_MOVE = 3'd3,
    UOP_DIV     = 3'd4,
    UOP_ST_PER  = 3'd5,
    UOP_ST_MOVE = 3'd6
  } uop_t;

  typedef enum logic [1:0] {
    JMP_NEXT   = 2'd0,
    JMP_LOOP   = 2'd1,
    JMP_ALWAYS = 2'd2
  } jmp_t;

  typedef struct packed {
    uop_t             uop;
    jmp_t             jmp;
    logic [UPC_W-1:0] target;
  } uword_t;

  localparam logic [UPC_W-1:0] UA_IDLE   = 4'd0;
  localparam logic [UPC_W-1:0] UA_RECALC = 4'd1;
  localparam logic [UPC_W-1:0] UA_MOVE   = 4'd6;

  // microprogram: period recompute at UA_RECALC, move command at UA_MOVE
  function automatic uword_t urom(input logic [UPC_W-1:0] pc);
    uword_t w;
    w = '{uop: UOP_NOP, jmp: JMP_ALWAYS, target: UA_IDLE};
    case (pc)
      4'd0: w = '{uop: UOP_NOP,     jmp: JMP_ALWAYS, target: UA_IDLE};
      4'd1: w = '{uop: UOP_LD_FREQ, jmp: JMP_NEXT,   target: UA_IDLE};
      4'd2: w = '{uop: UOP_DIV,     jmp: JMP_LOOP,   target: UA_IDLE};
      4'd3: w = '{uop: UOP_LD_PER,  jmp: JMP_NEXT,   target: UA_IDLE};
      4'd4: w = '{uop: UOP_DIV,     jmp: JMP_LOOP,   target: UA_IDLE};
      4'd5: w = '{uop: UOP_ST_PER,  jmp: JMP_ALWAYS, target: UA_IDLE};
      4'd6: w = '{uop: UOP_LD_MOVE, jmp: JMP_NEXT,   target: UA_IDLE};
      4'd7: w = '{uop: UOP_DIV,     jmp: JMP_LOOP,   target: UA_IDLE};
      4'd8: w = '{uop: UOP_ST_MOVE, jmp: JMP_ALWAYS, target: UA_IDLE};
      default: w = '{uop: UOP_NOP, jmp: JMP_ALWAYS, target: UA_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/stepper_pulse_generator.sv @@
`timescale 1ns / 1ps
// Timer tick transaction: registered at acceptance, one tick per cycle unless stalled.
// Move transaction: angle loaded, divided by the shared one-bit-per-cycle divider and
// stored by ST_MOVE; input stalls until the result is written.
// Speed or step-angle write: frequency then period recomputed on the same divider,
// input stalled meanwhile. Synchronous active-low reset: stopped, period 65536.
module stepper_pulse_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  spg_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output spg_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [spg_pkg::CFG_IW-1:0]    cfg_idx,
  input  logic [spg_pkg::CFG_DW-1:0]    cfg_wdata
);

  localparam int DIVD_W  = spg_pkg::DIVD_W;
  localparam int DVSR_W  = spg_pkg::DVSR_W;
  localparam int CNT_W   = spg_pkg::CNT_W;
  localparam int PER_W   = spg_pkg::PER_W;
  localparam int STEPS_W = spg_pkg::STEPS_W;
  localparam int UPC_W   = spg_pkg::UPC_W;

  // configuration
  logic [spg_pkg::SPEED_W-1:0] speed_r;
  logic [spg_pkg::ANGLE_W-1:0] step_angle_r;
  logic                        dir_r;
  logic                        recalc_pend_r, recalc_pend_nxt;

  // motor state
  logic [STEPS_W-1:0] rem_steps_r, rem_steps_nxt;
  logic               busy_r, busy_nxt;
  logic               running_r, running_nxt;
  logic [PER_W-1:0]   tick_r, tick_nxt;
  logic [PER_W-1:0]   period_r, period_nxt;

  // sequencer and divider
  logic [UPC_W-1:0]            upc_r, upc_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [DIVD_W-1:0]           dvd_r, dvd_nxt;
  logic [DVSR_W-1:0]           prem_r, prem_nxt;
  logic [DVSR_W-1:0]           dvsr_r, dvsr_nxt;
  logic [spg_pkg::MOVE_W-1:0]  move_angle_r, move_angle_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  spg_pkg::out_item_t   out_data_r, out_data_nxt;

  spg_pkg::uword_t   uw;
  logic              idle;
  logic              out_free;
  logic              in_acc;
  logic              last_step;
  logic [DVSR_W-1:0] angle_eff;
  logic [DVSR_W:0]   rem_sh;
  logic              rem_ge;
  logic [DVSR_W-1:0] freq_q;
  logic [PER_W-1:0]  tick_inc;
  logic              cfg_period_wr;

  assign uw        = spg_pkg::urom(upc_r);
  assign idle      = (upc_r == spg_pkg::UA_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !(idle && !recalc_pend_r && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign last_step = (cnt_r == CNT_W'(1));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign angle_eff = (step_angle_r == '0) ? DVSR_W'(1) : DVSR_W'(step_angle_r);
  assign rem_sh    = {prem_r, dvd_r[DIVD_W-1]};
  assign rem_ge    = (rem_sh >= {1'b0, dvsr_r});
  assign freq_q    = dvd_r[DVSR_W-1:0];
  assign tick_inc  = tick_r + PER_W'(1);

  assign cfg_period_wr = cfg_we &&
                         ((cfg_idx == spg_pkg::CFG_SPEED) || (cfg_idx == spg_pkg::CFG_STEP_ANGLE));

  // sequencer
  always_comb begin
    upc_nxt         = upc_r;
    recalc_pend_nxt = recalc_pend_r;
    if (idle) begin
      if (recalc_pend_r) begin
        upc_nxt         = spg_pkg::UA_RECALC;
        recalc_pend_nxt = 1'b0;
      end else if (in_acc && (in_data.mode == spg_pkg::MODE_MOVE)) begin
        upc_nxt = spg_pkg::UA_MOVE;
      end
    end else begin
      case (uw.jmp)
        spg_pkg::JMP_NEXT:   upc_nxt = upc_r + UPC_W'(1);
        spg_pkg::JMP_LOOP:   upc_nxt = last_step ? upc_r + UPC_W'(1) : upc_r;
        spg_pkg::JMP_ALWAYS: upc_nxt = uw.target;
        default:             upc_nxt = spg_pkg::UA_IDLE;
      endcase
    end
    // a later write queues another recompute after the current one
    if (cfg_period_wr) begin
      recalc_pend_nxt = 1'b1;
    end
  end

  // datapath
  always_comb begin
    cnt_nxt        = cnt_r;
    dvd_nxt        = dvd_r;
    prem_nxt       = prem_r;
    dvsr_nxt       = dvsr_r;
    move_angle_nxt = move_angle_r;
    rem_steps_nxt  = rem_steps_r;
    busy_nxt       = busy_r;
    running_nxt    = running_r;
    tick_nxt       = tick_r;
    period_nxt     = period_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;

    if (idle && in_acc) begin
      if (in_data.mode == spg_pkg::MODE_MOVE) begin
        move_angle_nxt = in_data.angle_deg;
      end else begin
        if (running_r) begin
          tick_nxt = tick_inc;
          if (tick_inc >= period_r) begin
            tick_nxt = '0;
            if (rem_steps_r == '0) begin
              running_nxt = 1'b0;
              busy_nxt    = 1'b0;
            end else begin
              rem_steps_nxt = rem_steps_r - STEPS_W'(1);
            end
          end
        end
        out_valid_nxt = 1'b1;
      end
    end

    case (uw.uop)
      spg_pkg::UOP_LD_FREQ: begin
        dvd_nxt  = DIVD_W'(speed_r) * DIVD_W'(100);
        dvsr_nxt = angle_eff;
        prem_nxt = '0;
        cnt_nxt  = CNT_W'(DIVD_W);
      end
      spg_pkg::UOP_LD_PER: begin
        dvd_nxt  = DIVD_W'(spg_pkg::TIMER_CLOCK_HZ);
        dvsr_nxt = (freq_q == '0) ? DVSR_W'(1) : freq_q;
        prem_nxt = '0;
        cnt_nxt  = CNT_W'(DIVD_W);
      end
      spg_pkg::UOP_LD_MOVE: begin
        dvd_nxt  = DIVD_W'(move_angle_r) * DIVD_W'(100);
        dvsr_nxt = angle_eff;
        prem_nxt = '0;
        cnt_nxt  = CNT_W'(DIVD_W);
      end
      spg_pkg::UOP_DIV: begin
        // restoring division, one quotient bit per cycle shifted into dvd_r
        prem_nxt = rem_ge ? DVSR_W'(rem_sh - {1'b0, dvsr_r}) : rem_sh[DVSR_W-1:0];
        dvd_nxt  = {dvd_r[DIVD_W-2:0], rem_ge};
        cnt_nxt  = cnt_r - CNT_W'(1);
      end
      spg_pkg::UOP_ST_PER: begin
        if (dvd_r > DIVD_W'(spg_pkg::PERIOD_MAX)) begin
          period_nxt = PER_W'(spg_pkg::PERIOD_MAX);
        end else if (dvd_r < DIVD_W'(spg_pkg::PERIOD_MIN)) begin
          period_nxt = PER_W'(spg_pkg::PERIOD_MIN);
        end else begin
          period_nxt = PER_W'(dvd_r);
        end
      end
      spg_pkg::UOP_ST_MOVE: begin
        // count replaced, timer keeps its phase; zero steps only clears busy
        rem_steps_nxt = dvd_r[STEPS_W-1:0];
        busy_nxt      = (dvd_r[STEPS_W-1:0] != '0);
        if (dvd_r[STEPS_W-1:0] != '0) begin
          running_nxt = 1'b1;
        end
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase

    out_data_nxt.step_level   = running_nxt && (tick_nxt < (period_r >> 1));
    out_data_nxt.dir_level    = dir_r;
    out_data_nxt.busy_res     = busy_nxt;
    out_data_nxt.steps_left   = rem_steps_nxt;
    out_data_nxt.period_ticks = period_r;
    if (!out_valid_nxt || (out_valid_r && out_stall)) begin
      out_data_nxt = out_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r       <= '0;
      step_angle_r  <= spg_pkg::ANGLE_W'(180);
      dir_r         <= 1'b1;
      recalc_pend_r <= 1'b0;
      rem_steps_r   <= '0;
      busy_r        <= 1'b0;
      running_r     <= 1'b0;
      tick_r        <= '0;
      period_r      <= PER_W'(spg_pkg::PERIOD_MAX);
      upc_r         <= spg_pkg::UA_IDLE;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          spg_pkg::CFG_SPEED:      speed_r      <= cfg_wdata[spg_pkg::SPEED_W-1:0];
          spg_pkg::CFG_STEP_ANGLE: step_angle_r <= cfg_wdata[spg_pkg::ANGLE_W-1:0];
          spg_pkg::CFG_DIR:        dir_r        <= cfg_wdata[0];
          default: ;
        endcase
      end
      recalc_pend_r <= recalc_pend_nxt;
      rem_steps_r   <= rem_steps_nxt;
      busy_r        <= busy_nxt;
      running_r     <= running_nxt;
      tick_r        <= tick_nxt;
      period_r      <= period_nxt;
      upc_r         <= upc_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    dvd_r        <= dvd_nxt;
    prem_r       <= prem_nxt;
    dvsr_r       <= dvsr_nxt;
    move_angle_r <= move_angle_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RECALC_WAIT = 2 * spg_pkg::DIVD_W + 5 + 8;
  localparam int DRAIN_TAIL  = 4;
  localparam int PHASE_ITEMS = 12;
  localparam int N_PHASES    = 8;
  localparam int HALF_RUN    = 390;
  localparam int REST_RUN    = 420;
  localparam int MOVE_W      = spg_pkg::MOVE_W;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  spg_pkg::in_item_t          in_data;
  logic                       out_valid;
  logic                       out_stall;
  spg_pkg::out_item_t         out_data;
  logic                       cfg_we;
  logic [spg_pkg::CFG_IW-1:0] cfg_idx;
  logic [spg_pkg::CFG_DW-1:0] cfg_wdata;

  stepper_pulse_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Step timer model plus the queue of outputs it has promised
  class pulse_checker;
    int unsigned                   speed;
    int unsigned                   step_angle;
    bit                            dir;
    bit [spg_pkg::STEPS_W-1:0]     steps;
    bit                            busy;
    bit                            running;
    bit [spg_pkg::PER_W-1:0]       tick;
    bit [spg_pkg::PER_W-1:0]       period;
    spg_pkg::out_item_t            pending_outputs[$];
    int                            errors;

    function new();
      speed = 0;
      step_angle = 180;
      dir = 1'b1;
      steps = '0;
      busy = 1'b0;
      running = 1'b0;
      tick = '0;
      errors = 0;
      recalc_period();
    endfunction

    function int unsigned divisor();
      return (step_angle == 0) ? 1 : step_angle;
    endfunction

    function void recalc_period();
      int unsigned freq;
      int unsigned per;
      freq = (speed * 100) / divisor();
      if (freq == 0) freq = 1;
      per = spg_pkg::TIMER_CLOCK_HZ / freq;
      if (per > spg_pkg::PERIOD_MAX) per = spg_pkg::PERIOD_MAX;
      if (per < spg_pkg::PERIOD_MIN) per = spg_pkg::PERIOD_MIN;
      period = per[spg_pkg::PER_W-1:0];
    endfunction

    function void set_reg(logic [spg_pkg::CFG_IW-1:0] idx, int unsigned value);
      case (idx)
        spg_pkg::CFG_SPEED: begin
          speed = value & 32'hFF;
          recalc_period();
        end
        spg_pkg::CFG_STEP_ANGLE: begin
          step_angle = value & 32'h3FFF;
          recalc_period();
        end
        spg_pkg::CFG_DIR: dir = value[0];
        default: ;
      endcase
    endfunction

    function void note_command(spg_pkg::in_item_t it);
      spg_pkg::out_item_t want;
      int unsigned        n;
      if (it.mode == spg_pkg::MODE_MOVE) begin
        n = (it.angle_deg * 100) / divisor();
        steps = n[spg_pkg::STEPS_W-1:0];
        busy = (steps != 0);
        if (busy) running = 1'b1;
      end else if (running) begin
        tick = tick + 1'b1;
        if (tick >= period) begin
          // reload: count down, or stop once the count is spent
          tick = '0;
          if (steps == 0) begin
            running = 1'b0;
            busy = 1'b0;
          end else begin
            steps = steps - 1'b1;
          end
        end
      end
      want.step_level   = running && (tick < (period >> 1));
      want.dir_level    = dir;
      want.busy_res     = busy;
      want.steps_left   = steps;
      want.period_ticks = period;
      pending_outputs.push_back(want);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_output(spg_pkg::out_item_t got);
      spg_pkg::out_item_t want;
      if (pending_outputs.size() == 0) begin
        errors++;
        $display("%0t: output expected none, actual %h", $time, got);
        return;
      end
      want = pending_outputs.pop_front();
      compare("step_level", 32'(want.step_level), 32'(got.step_level));
      compare("dir_level", 32'(want.dir_level), 32'(got.dir_level));
      compare("busy_res", 32'(want.busy_res), 32'(got.busy_res));
      compare("steps_left", 32'(want.steps_left), 32'(got.steps_left));
      compare("period_ticks", 32'(want.period_ticks), 32'(got.period_ticks));
    endfunction
  endclass

  pulse_checker sb = new();
  bit           calm [2];
  int           out_hold;
  int           cycles;

  // idle cycles before the next input, or stall cycles on the output; runs of zero now and then
  function automatic int draw_wait(input int side);
    if ($urandom_range(0, 63) == 0) calm[side] = ~calm[side];
    return calm[side] ? 0 : int'($urandom_range(0, 17));
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_output(out_data);
        out_hold = draw_wait(1);
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send(input logic mode, input logic [MOVE_W-1:0] angle);
    spg_pkg::in_item_t it;
    int                gap;
    it.mode = mode;
    it.angle_deg = angle;
    gap = draw_wait(0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_command(it);
  endtask

  task automatic tick_run(input int len);
    repeat (len) send(spg_pkg::MODE_TICK, MOVE_W'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(input logic [spg_pkg::CFG_IW-1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value[spg_pkg::CFG_DW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
    // speed and step angle start a period recompute that holds the input off
    repeat (RECALC_WAIT) @(posedge clk);
  endtask

  task automatic run_phase(input int budget);
    int done_n;
    int kind;
    int len;
    done_n = 0;
    while (done_n < budget) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        // move, then a short run of ticks
        if ($urandom_range(0, 3) == 0)
          send(spg_pkg::MODE_MOVE, MOVE_W'($urandom_range(1, 3)));
        else
          send(spg_pkg::MODE_MOVE, MOVE_W'($urandom));
        len = $urandom_range(1, 6);
        tick_run(len);
        done_n += len + 1;
      end else if (kind < 75) begin
        len = $urandom_range(1, 6);
        repeat (len) send(1'($urandom_range(0, 1)), MOVE_W'($urandom));
        done_n += len;
      end else begin
        // zero-step move, the timer may still be running
        send(spg_pkg::MODE_MOVE, '0);
        len = $urandom_range(1, 4);
        tick_run(len);
        done_n += len + 1;
      end
    end
  endtask

  initial begin
    int          ph;
    int unsigned spd;
    int unsigned ang;
    int unsigned dr;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    cycles = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: tick while stopped, zero-step move, long move, cancel while running
    send(spg_pkg::MODE_TICK, 8'hFF);
    send(spg_pkg::MODE_MOVE, 8'd0);
    send(spg_pkg::MODE_MOVE, 8'd255);
    repeat (3) send(spg_pkg::MODE_TICK, 8'h00);
    send(spg_pkg::MODE_MOVE, 8'd0);
    repeat (2) send(spg_pkg::MODE_TICK, 8'hAA);
    send(spg_pkg::MODE_MOVE, 8'd85);
    send(spg_pkg::MODE_TICK, 8'h55);
    drain();

    // fastest speed with a zero step angle (taken as one): shortest period
    write_reg(spg_pkg::CFG_SPEED, 255);
    write_reg(spg_pkg::CFG_STEP_ANGLE, 0);
    write_reg(spg_pkg::CFG_DIR, 0);
    send(spg_pkg::MODE_MOVE, 8'd1);
    repeat (2) send(spg_pkg::MODE_TICK, 8'h0F);
    send(spg_pkg::MODE_MOVE, 8'd255);
    repeat (2) send(spg_pkg::MODE_TICK, 8'hF0);
    send(spg_pkg::MODE_MOVE, 8'd0);
    drain();

    // slowest: widest step angle, lowest nonzero speed
    write_reg(spg_pkg::CFG_STEP_ANGLE, 16383);
    write_reg(spg_pkg::CFG_SPEED, 1);
    write_reg(spg_pkg::CFG_DIR, 1);
    send(spg_pkg::MODE_MOVE, 8'd255);
    repeat (2) send(spg_pkg::MODE_TICK, 8'h33);
    send(spg_pkg::MODE_MOVE, 8'd163);
    drain();

    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin spd = 255; ang = 20;   dr = 0; end
        1: begin spd = 200; ang = 17;   dr = 1; end
        2: begin spd = 0;   ang = 9000; dr = 0; end
        3: begin spd = 255; ang = 1;    dr = 1; end
        default: begin
          spd = $urandom_range(100, 255);
          ang = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                            : $urandom_range(1, 40);
          dr = $urandom_range(0, 1);
        end
      endcase
      write_reg(spg_pkg::CFG_SPEED, spd);
      write_reg(spg_pkg::CFG_STEP_ANGLE, ang);
      write_reg(spg_pkg::CFG_DIR, dr);
      run_phase(PHASE_ITEMS);
      drain();
    end

    // one full period at the shortest period: the reload counts down or stops the timer
    write_reg(spg_pkg::CFG_SPEED, 255);
    write_reg(spg_pkg::CFG_STEP_ANGLE, 1);
    send(spg_pkg::MODE_MOVE, 8'd1);
    tick_run(HALF_RUN);
    if ($urandom_range(0, 1))
      send(spg_pkg::MODE_MOVE, 8'd0);
    else
      send(spg_pkg::MODE_MOVE, MOVE_W'($urandom_range(1, 255)));
    tick_run(REST_RUN);
    drain();

    repeat (DRAIN_TAIL) @(posedge clk);
    if (sb.errors == 0 && sb.pending_outputs.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
